// ----- rtl/countdown_timer_table_top_defines.svh -----
// Assertion helpers shared by the timer table RTL.
`ifndef COUNTDOWN_TIMER_TABLE_TOP_DEFINES_SVH
`define COUNTDOWN_TIMER_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdtt same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CDTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdtt next-cycle check failed");

`endif

// ----- rtl/cdtt_pkg.sv -----
`timescale 1ns / 1ps
package cdtt_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int SLOT_NUM_W      = 6;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD       = 2'd0;
  localparam logic [1:0] KIND_DELETE    = 2'd1;
  localparam logic [1:0] KIND_FIRED     = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_ADD,
    OP_SHIFT,
    OP_TICK
  } cell_op_t;

  typedef struct packed {
    logic [14:0]        period;
    logic signed [15:0] counter;
    logic signed [15:0] repeats;
    logic [7:0]         tag;
  } slot_data_t;

  typedef struct packed {
    logic       active;
    slot_data_t data;
  } slot_entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t               op;
    logic [SLOT_NUM_W-1:0]  index;
    logic [14:0]            elapsed;
    logic [14:0]            period;
    logic signed [15:0]     repeats;
    logic [7:0]             tag;
  } cell_cmd_t;

  // Driven only by the cell that the broadcast index selects, zero elsewhere.
  typedef struct packed {
    logic       fire;
    logic       remove;
    logic [7:0] tag;
  } cell_stat_t;

endpackage

// ----- rtl/cdtt_cell.sv -----
`timescale 1ns / 1ps
module cdtt_cell #(
  parameter int SLOT_ID = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdtt_pkg::cell_cmd_t  cell_cmd,
  input  cdtt_pkg::slot_entry_t up_entry,
  output cdtt_pkg::slot_entry_t own_entry,
  output cdtt_pkg::cell_stat_t cell_stat
);
  import cdtt_pkg::*;

  logic       active_r, active_nxt;
  slot_data_t data_r, data_nxt;

  logic                  is_sel;
  logic                  at_or_above;
  logic signed [16:0]    diff;
  logic signed [15:0]    cnt_sat;
  logic                  fire;

  assign is_sel      = (cell_cmd.index == SLOT_NUM_W'(SLOT_ID));
  assign at_or_above = (SLOT_NUM_W'(SLOT_ID) >= cell_cmd.index);

  assign diff    = $signed({data_r.counter[15], data_r.counter}) -
                   $signed({2'b00, cell_cmd.elapsed});
  assign cnt_sat = (diff < -17'sd32768) ? 16'sh8000 : diff[15:0];
  assign fire    = active_r && (cnt_sat <= 16'sd0);

  always_comb begin
    cell_stat = '0;
    if (is_sel) begin
      cell_stat.fire   = fire;
      cell_stat.remove = fire && (data_r.repeats == 16'sd1);
      cell_stat.tag    = data_r.tag;
    end
  end

  assign own_entry.active = active_r;
  assign own_entry.data   = data_r;

  always_comb begin
    active_nxt = active_r;
    data_nxt   = data_r;
    case (cell_cmd.op)
      OP_ADD: begin
        if (is_sel) begin
          active_nxt       = 1'b1;
          data_nxt.period  = cell_cmd.period;
          data_nxt.counter = $signed({1'b0, cell_cmd.period});
          data_nxt.repeats = cell_cmd.repeats;
          data_nxt.tag     = cell_cmd.tag;
        end
      end
      OP_SHIFT: begin
        // Every cell from the freed slot upward takes its upper neighbor.
        if (at_or_above) begin
          active_nxt = up_entry.active;
          data_nxt   = up_entry.data;
        end
      end
      OP_TICK: begin
        if (is_sel) begin
          data_nxt.counter = cnt_sat;
          if (fire) begin
            if (data_r.repeats > 16'sd1) begin
              data_nxt.repeats = data_r.repeats - 16'sd1;
              data_nxt.counter = $signed({1'b0, data_r.period});
            end else if (data_r.repeats < 16'sd0) begin
              data_nxt.counter = $signed({1'b0, data_r.period});
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/cdtt_ctrl.sv -----
`timescale 1ns / 1ps
`include "countdown_timer_table_top_defines.svh"
module cdtt_ctrl #(
  parameter int TIMER_SLOTS = cdtt_pkg::DEF_TIMER_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [14:0]              in_period,
  input  logic signed [15:0]       in_repeat_count,
  input  logic [7:0]               in_callback_tag,
  input  logic [7:0]               in_slot_index,
  input  logic [14:0]              in_elapsed,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_reply_kind,
  output logic [5:0]               out_slot_number,
  output logic                     out_table_full,
  output logic [7:0]               out_fired_tag,
  output logic                     out_last,
  input  logic [TIMER_SLOTS-1:0]   slot_active,
  input  cdtt_pkg::cell_stat_t     cell_stat [TIMER_SLOTS],
  output cdtt_pkg::cell_cmd_t      cell_cmd
);
  import cdtt_pkg::*;

  localparam int IDX_W = $clog2(TIMER_SLOTS);
  localparam int PTR_W = $clog2(TIMER_SLOTS + 1);

  ctrl_state_t state_r, state_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [14:0]      elapsed_r;

  logic                  out_valid_r;
  logic [1:0]            out_reply_kind_r, out_reply_kind_nxt;
  logic [5:0]            out_slot_number_r, out_slot_number_nxt;
  logic                  out_table_full_r, out_table_full_nxt;
  logic [7:0]            out_fired_tag_r, out_fired_tag_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;

  logic                  out_free;
  logic                  in_accept;
  logic                  ptr_adv;
  logic                  walk_done;
  logic [IDX_W-1:0]      ptr_idx;
  logic [SLOT_NUM_W-1:0] free_idx;
  logic                  table_full;
  cell_stat_t            sel_stat;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign ptr_idx    = ptr_r[IDX_W-1:0];
  assign table_full = slot_active[TIMER_SLOTS-1];

  // Active entries always form a prefix, so the first free slot is the
  // lowest inactive one.
  always_comb begin
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_idx = SLOT_NUM_W'(i);
      end
    end
  end

  always_comb begin
    sel_stat = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      sel_stat.fire   = sel_stat.fire   | cell_stat[i].fire;
      sel_stat.remove = sel_stat.remove | cell_stat[i].remove;
      sel_stat.tag    = sel_stat.tag    | cell_stat[i].tag;
    end
  end

  always_comb begin
    walk_done = 1'b0;
    if (ptr_r == PTR_W'(TIMER_SLOTS)) begin
      walk_done = 1'b1;
    end else if (!slot_active[ptr_idx]) begin
      walk_done = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_cmd == CMD_TICK) && (in_elapsed != 15'd0)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs: input stall, cell broadcast, result beat and walk pointer advance.
  always_comb begin
    in_stall            = !((state_r == ST_IDLE) && out_free);
    cell_cmd.op         = OP_IDLE;
    cell_cmd.index      = '0;
    cell_cmd.elapsed    = elapsed_r;
    cell_cmd.period     = in_period;
    cell_cmd.repeats    = in_repeat_count;
    cell_cmd.tag        = in_callback_tag;
    out_load            = 1'b0;
    out_reply_kind_nxt  = KIND_TICK_DONE;
    out_slot_number_nxt = '0;
    out_table_full_nxt  = 1'b0;
    out_fired_tag_nxt   = '0;
    out_last_nxt        = 1'b1;
    ptr_adv             = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_ADD: begin
              out_load           = 1'b1;
              out_reply_kind_nxt = KIND_ADD;
              if (table_full) begin
                out_table_full_nxt = 1'b1;
              end else begin
                cell_cmd.op         = OP_ADD;
                cell_cmd.index      = free_idx;
                out_slot_number_nxt = free_idx;
              end
            end
            CMD_DELETE: begin
              out_load           = 1'b1;
              out_reply_kind_nxt = KIND_DELETE;
              if (in_slot_index < 8'(TIMER_SLOTS)) begin
                cell_cmd.op    = OP_SHIFT;
                cell_cmd.index = in_slot_index[SLOT_NUM_W-1:0];
              end
            end
            CMD_TICK: begin
              out_load = (in_elapsed == 15'd0);
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!walk_done) begin
          cell_cmd.index = SLOT_NUM_W'(ptr_idx);
          if (!sel_stat.fire) begin
            cell_cmd.op = OP_TICK;
            ptr_adv     = 1'b1;
          end else if (out_free) begin
            out_load            = 1'b1;
            out_reply_kind_nxt  = KIND_FIRED;
            out_slot_number_nxt = SLOT_NUM_W'(ptr_idx);
            out_fired_tag_nxt   = sel_stat.tag;
            out_last_nxt        = 1'b0;
            // A removed entry is replaced by its neighbor, which is
            // processed next from the same slot.
            if (sel_stat.remove) begin
              cell_cmd.op = OP_SHIFT;
            end else begin
              cell_cmd.op = OP_TICK;
              ptr_adv     = 1'b1;
            end
          end
        end
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_accept) begin
      ptr_nxt = '0;
    end else if (ptr_adv) begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (in_accept) begin
      elapsed_r <= in_elapsed;
    end
    if (out_load) begin
      out_reply_kind_r  <= out_reply_kind_nxt;
      out_slot_number_r <= out_slot_number_nxt;
      out_table_full_r  <= out_table_full_nxt;
      out_fired_tag_r   <= out_fired_tag_nxt;
      out_last_r        <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_reply_kind_r;
  assign out_slot_number = out_slot_number_r;
  assign out_table_full  = out_table_full_r;
  assign out_fired_tag   = out_fired_tag_r;
  assign out_last        = out_last_r;

  `CDTT_ASSERT_NOW(a_busy_stalls_input, clk, rst_n, state_r != ST_IDLE, in_stall)
  `CDTT_ASSERT_NOW(a_active_prefix, clk, rst_n, 1'b1,
                   ((slot_active + 1'b1) & slot_active) == '0)
  `CDTT_ASSERT_NOW(a_fire_waits_for_output, clk, rst_n,
                   (state_r == ST_WALK) && !walk_done && sel_stat.fire && !out_free,
                   cell_cmd.op == OP_IDLE)
  `CDTT_ASSERT_NOW(a_fire_not_last, clk, rst_n,
                   out_valid_r && (out_reply_kind_r == KIND_FIRED), !out_last_r)

endmodule

// ----- rtl/countdown_timer_table_top.sv -----
`timescale 1ns / 1ps
// Countdown timer table: a compact row of TIMER_SLOTS timer cells.
// Input beats carry a command: add a timer (period, repeat count, tag),
// delete a slot, or tick by an elapsed time. An input beat is taken when
// in_valid is high and in_stall is low; a result beat leaves when out_valid
// is high and out_stall is low. One command is worked on at a time.
// Add and delete give a single reply, which sits in the output register
// the cycle after the input beat. A tick walks the active entries in
// order through the cell row; each cell that expires gives one fire beat
// (last low), and a closing tick-finished beat with last high ends the
// command. A tick with zero elapsed time gives only that closing beat.
// Every entry, kept or removed on its final repeat, is visited once: a
// removed entry's neighbor moves into its slot and is visited from there.
// When the receiver stalls, the walk holds at the firing slot and the
// input stays stalled until every result of the command has left.
// Reset (synchronous, rst_n low) clears all slots and any pending result.
module countdown_timer_table_top #(
  parameter int TIMER_SLOTS = cdtt_pkg::DEF_TIMER_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [14:0]        in_period,
  input  logic signed [15:0] in_repeat_count,
  input  logic [7:0]         in_callback_tag,
  input  logic [7:0]         in_slot_index,
  input  logic [14:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_reply_kind,
  output logic [5:0]         out_slot_number,
  output logic               out_table_full,
  output logic [7:0]         out_fired_tag,
  output logic               out_last
);
  import cdtt_pkg::*;

  cell_cmd_t             cell_cmd;
  cell_stat_t            cell_stat [TIMER_SLOTS];
  slot_entry_t           entry [TIMER_SLOTS+1];
  logic [TIMER_SLOTS-1:0] slot_active;

  // The slot above the top cell is always empty.
  assign entry[TIMER_SLOTS] = '0;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    cdtt_cell #(
      .SLOT_ID (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_cmd  (cell_cmd),
      .up_entry  (entry[g+1]),
      .own_entry (entry[g]),
      .cell_stat (cell_stat[g])
    );
    assign slot_active[g] = entry[g].active;
  end

  cdtt_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .in_callback_tag (in_callback_tag),
    .in_slot_index   (in_slot_index),
    .in_elapsed      (in_elapsed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reply_kind  (out_reply_kind),
    .out_slot_number (out_slot_number),
    .out_table_full  (out_table_full),
    .out_fired_tag   (out_fired_tag),
    .out_last        (out_last),
    .slot_active     (slot_active),
    .cell_stat       (cell_stat),
    .cell_cmd        (cell_cmd)
  );

endmodule
